// ===== hdl/tbn_pkg.sv =====
// shared types, codes and role logic for the tournament barrier node
package tbn_pkg;

   localparam int NODE_LIMIT   = 64;
   localparam int MAX_NODES_DEF = 64;
   localparam int ROUND_MAX    = 6;

   // role of this node in one round
   localparam logic [2:0] ROLE_NONE     = 3'd0;
   localparam logic [2:0] ROLE_BYE      = 3'd1;
   localparam logic [2:0] ROLE_WINNER   = 3'd2;
   localparam logic [2:0] ROLE_LOSER    = 3'd3;
   localparam logic [2:0] ROLE_CHAMPION = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_SEND    = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_DROP    = 2'd2;

   // round walker operations
   localparam logic [1:0] KOP_HOLD = 2'd0;
   localparam logic [1:0] KOP_INC  = 2'd1;
   localparam logic [1:0] KOP_DEC  = 2'd2;
   localparam logic [1:0] KOP_ZERO = 2'd3;

   // config register indexes
   localparam logic CSR_NODE_COUNT = 1'b0;
   localparam logic CSR_NODE_RANK  = 1'b1;

   typedef struct packed {
      logic [2:0] role;
      logic [5:0] opp;
   } role_type;

   typedef struct packed {
      logic       load;
      logic [1:0] k_op;
      logic       emit;
      logic [1:0] emit_kind;
      logic       emit_last;
      logic       pend_set;
      logic       pend_clr;
      logic       wait_set;
      logic       wait_clr;
   } ctl_cmd_type;

   typedef struct packed {
      logic       cmd_msg;
      logic       waiting;
      logic       k_eq_cur;
      logic       msg_ok;
      logic       valid_rank;
      logic       k_gt_rounds;
      logic       k_zero;
      logic [2:0] role;
      logic       pend_k;
      logic       out_free;
   } dp_stat_type;

   // role and opponent of a node in round k
   function automatic role_type role_calc(input logic [2:0] k, input logic [6:0] n,
                                          input logic [5:0] rk);
      role_type   res;
      logic [7:0] full;
      logic [7:0] half;
      logic [7:0] m;
      logic [7:0] sum;
      logic [7:0] diff;
      full = 8'd1 << k;
      half = full >> 1;
      m    = {2'b00, rk} & (full - 8'd1);
      sum  = {2'b00, rk} + half;
      diff = {2'b00, rk} - half;
      res.role = ROLE_NONE;
      res.opp  = 6'd0;
      if (k == 3'd0 || k == 3'd7) begin
         res.role = ROLE_NONE;
      end else if (m == 8'd0 && sum >= {1'b0, n}) begin
         res.role = ROLE_BYE;
      end else if (m == 8'd0 && full < {1'b0, n}) begin
         res.role = ROLE_WINNER;
         res.opp  = sum[5:0];
      end else if (m == half) begin
         res.role = ROLE_LOSER;
         res.opp  = diff[5:0];
      end else if (rk == 6'd0 && full >= {1'b0, n}) begin
         res.role = ROLE_CHAMPION;
         res.opp  = half[5:0];
      end
      return res;
   endfunction

   // number of rounds: smallest r with 2^r >= n
   function automatic logic [2:0] round_total(input logic [6:0] n);
      logic [2:0] r;
      r = 3'd0;
      for (int i = 0; i < ROUND_MAX; i++) begin
         if ((8'd1 << i) < {1'b0, n}) r = 3'(i + 1);
      end
      return r;
   endfunction

endpackage

// ===== hdl/tbn_ctrl.sv =====
// round sequencer state machine of the barrier node
module tbn_ctrl import tbn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_accept,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd,
   output logic        busy
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_DECODE  = 2'd1;
   localparam logic [1:0] ST_CLIMB   = 2'd2;
   localparam logic [1:0] ST_DESCEND = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (in_accept) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!stat.cmd_msg) begin
               // arrive
               if (stat.waiting) begin
                  state_in = ST_IDLE;
               end else if (!stat.valid_rank) begin
                  cmd.k_op = KOP_ZERO;
                  state_in = ST_DESCEND;
               end else begin
                  state_in = ST_CLIMB;
               end
            end else if (!stat.msg_ok || (!(stat.waiting && stat.k_eq_cur) && stat.pend_k)) begin
               if (stat.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_DROP;
                  cmd.emit_last = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (stat.waiting && stat.k_eq_cur) begin
               if (stat.role == ROLE_WINNER) begin
                  cmd.k_op = KOP_INC;
                  state_in = ST_CLIMB;
               end else if (stat.role == ROLE_LOSER) begin
                  cmd.k_op = KOP_DEC;
                  state_in = ST_DESCEND;
               end else if (stat.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_SEND;
                  cmd.k_op      = KOP_DEC;
                  state_in      = ST_DESCEND;
               end
            end else begin
               // early message, latch it
               cmd.pend_set = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CLIMB: begin
            if (stat.k_gt_rounds) begin
               cmd.k_op = KOP_ZERO;
               state_in = ST_DESCEND;
            end else begin
               case (stat.role)
                  ROLE_WINNER: begin
                     if (stat.pend_k) begin
                        cmd.pend_clr = 1'b1;
                        cmd.k_op     = KOP_INC;
                     end else begin
                        cmd.wait_set = 1'b1;
                        state_in     = ST_IDLE;
                     end
                  end
                  ROLE_LOSER: begin
                     if (stat.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_SEND;
                        cmd.emit_last = !stat.pend_k;
                        if (stat.pend_k) begin
                           cmd.pend_clr = 1'b1;
                           cmd.k_op     = KOP_DEC;
                           state_in     = ST_DESCEND;
                        end else begin
                           cmd.wait_set = 1'b1;
                           state_in     = ST_IDLE;
                        end
                     end
                  end
                  ROLE_CHAMPION: begin
                     if (!stat.pend_k) begin
                        cmd.wait_set = 1'b1;
                        state_in     = ST_IDLE;
                     end else if (stat.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_SEND;
                        cmd.pend_clr  = 1'b1;
                        cmd.k_op      = KOP_DEC;
                        state_in      = ST_DESCEND;
                     end
                  end
                  default: begin
                     cmd.k_op = KOP_INC;
                  end
               endcase
            end
         end
         ST_DESCEND: begin
            if (stat.k_zero) begin
               if (stat.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_RELEASE;
                  cmd.emit_last = 1'b1;
                  cmd.wait_clr  = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (stat.role == ROLE_WINNER) begin
               if (stat.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_SEND;
                  cmd.k_op      = KOP_DEC;
               end
            end else begin
               cmd.k_op = KOP_DEC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/tbn_datapath.sv =====
// config, round state, role unit and result register of the barrier node
module tbn_datapath import tbn_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_cmd_type cmd,
   output dp_stat_type stat,
   input  logic        req_cmd,
   input  logic [2:0]  req_msg_round,
   input  logic [5:0]  req_msg_source,
   input  logic        cfg_write,
   input  logic        cfg_index,
   input  logic [6:0]  cfg_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [5:0]  rsp_dest_rank,
   output logic [2:0]  rsp_round_tag,
   output logic        rsp_last
);

   localparam int         CAP   = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
   localparam logic [6:0] CAP_V = 7'(CAP);

   logic [6:0] count_ff, count_in;
   logic [5:0] rank_ff, rank_in;
   logic       wait_ff, wait_in;
   logic [2:0] cur_ff, cur_in;
   logic [5:0] pend_ff, pend_in;
   logic [2:0] k_ff, k_in;
   logic       cmd_ff;
   logic [5:0] src_ff;
   logic       valid_ff, valid_in;
   logic [1:0] kind_ff;
   logic [5:0] dest_ff;
   logic [2:0] tag_ff;
   logic       last_ff;

   logic [6:0] n_eff;
   logic [2:0] rounds;
   role_type   rk_info;
   logic       k_in_range;
   logic [2:0] k_idx;

   assign n_eff      = (count_ff == 7'd0) ? 7'd1 : ((count_ff > CAP_V) ? CAP_V : count_ff);
   assign rounds     = round_total(n_eff);
   assign rk_info    = role_calc(k_ff, n_eff, rank_ff);
   assign k_in_range = (k_ff >= 3'd1) && (k_ff <= 3'(ROUND_MAX));
   assign k_idx      = k_ff - 3'd1;

   always_comb begin
      stat             = '0;
      stat.cmd_msg     = cmd_ff;
      stat.waiting     = wait_ff;
      stat.k_eq_cur    = (k_ff == cur_ff);
      stat.valid_rank  = ({1'b0, rank_ff} < n_eff);
      stat.k_gt_rounds = (k_ff > rounds);
      stat.k_zero      = (k_ff == 3'd0);
      stat.role        = rk_info.role;
      stat.pend_k      = k_in_range ? pend_ff[k_idx] : 1'b0;
      stat.out_free    = !valid_ff || !rsp_stall;
      stat.msg_ok      = stat.valid_rank && (k_ff >= 3'd1) && (k_ff <= rounds)
                         && (rk_info.role == ROLE_WINNER || rk_info.role == ROLE_LOSER
                             || rk_info.role == ROLE_CHAMPION)
                         && (rk_info.opp == src_ff);
   end

   always_comb begin
      count_in = count_ff;
      rank_in  = rank_ff;
      wait_in  = wait_ff;
      cur_in   = cur_ff;
      pend_in  = pend_ff;
      if (cmd.pend_set && k_in_range) pend_in[k_idx] = 1'b1;
      if (cmd.pend_clr && k_in_range) pend_in[k_idx] = 1'b0;
      if (cmd.wait_set) begin
         wait_in = 1'b1;
         cur_in  = k_ff;
      end
      if (cmd.wait_clr) begin
         wait_in = 1'b0;
         cur_in  = 3'd0;
      end
      if (cfg_write) begin
         case (cfg_index)
            CSR_NODE_COUNT: count_in = cfg_data;
            CSR_NODE_RANK:  rank_in  = cfg_data[5:0];
            default:        count_in = count_ff;
         endcase
         wait_in = 1'b0;
         cur_in  = 3'd0;
         pend_in = '0;
      end
   end

   always_comb begin
      case (cmd.k_op)
         KOP_INC:  k_in = k_ff + 3'd1;
         KOP_DEC:  k_in = k_ff - 3'd1;
         KOP_ZERO: k_in = 3'd0;
         default:  k_in = k_ff;
      endcase
      if (cmd.load) k_in = req_cmd ? req_msg_round : 3'd1;
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd8;
         rank_ff  <= 6'd0;
         wait_ff  <= 1'b0;
         cur_ff   <= 3'd0;
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rank_ff  <= rank_in;
         wait_ff  <= wait_in;
         cur_ff   <= cur_in;
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (cmd.load) begin
         cmd_ff <= req_cmd;
         src_ff <= req_msg_source;
      end
      if (cmd.emit) begin
         kind_ff <= cmd.emit_kind;
         last_ff <= cmd.emit_last;
         if (cmd.emit_kind == KIND_SEND) begin
            dest_ff <= rk_info.opp;
            tag_ff  <= k_ff;
         end else begin
            dest_ff <= 6'd0;
            tag_ff  <= 3'd0;
         end
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_dest_rank = dest_ff;
   assign rsp_round_tag = tag_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== hdl/tournament_barrier_node_core.sv =====
// top level of one tournament barrier node
//
//  channel   handshake            payload
//  req_      req_valid/req_stall  req_cmd, req_msg_round, req_msg_source
//  rsp_      rsp_valid/rsp_stall  rsp_kind, rsp_dest_rank, rsp_round_tag, rsp_last
//  csr_      csr_valid/csr_ready  csr_index, csr_wdata
//
// one item at a time: accept, a decode step, then one step per round visited
// on the way up and on the way down; no new item is taken until the walk ends
// the round walker emits at most one result per cycle into the result register
// a stalled result register holds the walker on any step that emits
// reset (synchronous) restores node_count 8, rank 0, idle, no latched messages
module tournament_barrier_node_core import tbn_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // input items
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_cmd,
   input  logic [2:0] req_msg_round,
   input  logic [5:0] req_msg_source,
   // result items
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [5:0] rsp_dest_rank,
   output logic [2:0] rsp_round_tag,
   output logic       rsp_last,
   // config writes
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata
);

   ctl_cmd_type cmd;
   dp_stat_type stat;
   logic        busy;
   logic        in_accept;
   logic        cfg_write;

   // items are taken only while the sequencer sits idle
   assign req_stall = busy;
   assign in_accept = req_valid && !busy;

   // config writes land only between items
   assign csr_ready = !busy;
   assign cfg_write = csr_valid && csr_ready;

   // sequencer: decode, climb the rounds, descend with wake-ups
   tbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   // config, pending flags, role unit, result register
   tbn_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_cmd        (req_cmd),
      .req_msg_round  (req_msg_round),
      .req_msg_source (req_msg_source),
      .cfg_write      (cfg_write),
      .cfg_index      (csr_index),
      .cfg_data       (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_dest_rank  (rsp_dest_rank),
      .rsp_round_tag  (rsp_round_tag),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   // an accepted item always enters the decode state
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted but sequencer not busy next cycle");

   // release and drop carry no destination or tag
   a_nonsend_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_SEND) |-> (rsp_dest_rank == 6'd0 && rsp_round_tag == 3'd0))
      else $error("non-send result with destination or tag");

   // release and drop always end an item
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_RELEASE || rsp_kind == KIND_DROP)) |-> rsp_last)
      else $error("release or drop without last");
`endif

endmodule
